// ===== rtl/pds_pkg.sv =====
// shared widths and constants of the pll divider search
package pds_pkg;

  localparam int REF_W   = 29;
  localparam int TGT_W   = 32;
  localparam int PD_W    = 5;
  localparam int FB_W    = 9;
  localparam int RATE_W  = 30;
  localparam int FREF_W  = 28;
  localparam int NUM_W   = 35;  // target * prediv
  localparam int PROD_W  = 37;  // fbdiv * fref
  localparam int STEP_W  = $clog2(PROD_W);

  localparam logic [REF_W-1:0]  DEFAULT_REF_HZ   = 29'd24000000;
  localparam logic [RATE_W-1:0] MAX_TARGET_HZ    = 30'd1000000000;
  localparam logic [REF_W-1:0]  MAX_FREF_PER_DIV = 29'd40000000;
  localparam logic [REF_W-1:0]  MIN_FREF_PER_DIV = 29'd5000000;
  localparam logic [FB_W-1:0]   FB_SKIP          = 9'd15;
  localparam logic [FB_W-1:0]   FB_MIN           = 9'd12;

endpackage

// ===== rtl/pds_rate_div.sv =====
// bit-serial restoring divider for the achieved rate: fbdiv * fref / prediv
module pds_rate_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pds_pkg::PROD_W-1:0]   dividend,
  input  logic [pds_pkg::PD_W-1:0]     divisor,
  output logic                         done,
  output logic [pds_pkg::RATE_W-1:0]   quotient
);
  import pds_pkg::*;

  logic                busy;
  logic [STEP_W-1:0]   cnt;
  logic [PROD_W-1:0]   dv;
  logic [PD_W-1:0]     dvsr;
  logic [PD_W-1:0]     rem;
  logic [RATE_W-1:0]   quot;

  logic [PD_W:0]       trial;
  logic                ge;
  logic [PD_W-1:0]     rem_next;

  // one quotient bit per cycle, msb first
  always_comb begin
    trial    = {rem, dv[PROD_W-1]};
    ge       = trial >= {1'b0, dvsr};
    rem_next = ge ? PD_W'(trial - {1'b0, dvsr}) : trial[PD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dv   <= dividend;
        dvsr <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem  <= rem_next;
        dv   <= {dv[PROD_W-2:0], 1'b0};
        quot <= {quot[RATE_W-2:0], ge};
        cnt  <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quot;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    busy && !start |-> rem < dvsr)
    else $error("rate divider remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("rate divider done without a running division");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("rate divider restarted while busy");

endmodule

// ===== rtl/pll_divider_search.sv =====
// pll divider search: best prediv / fbdiv for a requested pll output rate
//
//  channel  handshake               payload
//  -------  ----------------------  ----------------------------------------------
//  cfg      cfg_valid / cfg_ready   ref_clock_hz
//  in       in_valid / in_stall     target_rate
//  out      out_valid / out_stall   pre_divider, feedback_divider, achieved_rate, found
//
//  a full pre-divider trial runs 9 feedback divider steps and the 37-step rate divider
//  between its control states; out-of-range fbdiv ends it early, in S_RANGE or S_CHECK
//  out_valid rises once the search ends; the pre-divider window allows at most 28 trials
//  a request is taken in idle even while the previous result waits on out_stall;
//  the search then holds at its end. reset restores 24 MHz and clears the held settings
module pll_divider_search (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pds_pkg::REF_W-1:0]   ref_clock_hz,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pds_pkg::TGT_W-1:0]   target_rate,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pds_pkg::PD_W-1:0]    pre_divider,
  output logic [pds_pkg::FB_W-1:0]    feedback_divider,
  output logic [pds_pkg::RATE_W-1:0]  achieved_rate,
  output logic                        found
);
  import pds_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_RANGE, S_DIV, S_CHECK, S_START, S_RATE, S_UPDATE
  } state_t;

  localparam int CNT_W = $clog2(FB_W);
  localparam int PC_W  = PD_W + 1;

  state_t              state;
  logic [REF_W-1:0]    ref_reg;
  logic [FREF_W-1:0]   fref;
  logic [RATE_W-1:0]   fout;
  logic [PC_W-1:0]     p;
  logic [NUM_W-1:0]    num;
  logic [FREF_W-1:0]   rem1;
  logic [FB_W-1:0]     nbits;
  logic [FB_W-1:0]     fb;
  logic [CNT_W-1:0]    cnt;
  logic [PROD_W-1:0]   prod;
  logic [RATE_W-1:0]   rate;
  logic                found_any;
  logic [PD_W-1:0]     best_p;
  logic [FB_W-1:0]     best_fb;
  logic [RATE_W-1:0]   best_rate;
  logic [RATE_W-1:0]   best_delta;
  logic                finishing;
  logic [PD_W-1:0]     held_prediv;
  logic [FB_W-1:0]     held_fbdiv;
  logic [RATE_W-1:0]   held_rate;

  logic [REF_W-1:0]    prate;
  logic [FREF_W-1:0]   fref_in;
  logic [PC_W-1:0]     pmin;
  logic [FREF_W:0]     div_trial;
  logic                div_ge;
  logic [RATE_W-1:0]   delta;
  logic                search_end;
  logic                result_load;
  logic                div_done;
  logic [RATE_W-1:0]   div_quot;

  // smallest prediv that keeps fref / prediv at or below 40 MHz
  function automatic logic [PC_W-1:0] first_prediv(input logic [FREF_W-1:0] f);
    logic [PC_W-1:0] r;
    r = PC_W'(1);
    for (int k = 1; k < 7; k++) begin
      if ({1'b0, f} > REF_W'(k) * MAX_FREF_PER_DIV) r = PC_W'(k + 1);
    end
    return r;
  endfunction

  always_comb begin
    prate       = (ref_reg != '0) ? ref_reg : DEFAULT_REF_HZ;
    fref_in     = prate[REF_W-1:1];
    pmin        = first_prediv(fref_in);
    div_trial   = {rem1, nbits[FB_W-1]};
    div_ge      = div_trial >= {1'b0, fref};
    delta       = fout - rate;
    // loop ends on an exact match or zero fref, past the field maximum, or once fref / p drops below 5 MHz
    search_end  = finishing || p[PC_W-1]
                  || (REF_W'(p) * MIN_FREF_PER_DIV > {1'b0, fref});
    result_load = (state == S_MUL) && search_end && (!out_valid || !out_stall);
  end

  assign cfg_ready = !rst;
  assign in_stall  = rst || (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_reg <= DEFAULT_REF_HZ;
    end else if (cfg_valid && cfg_ready) begin
      ref_reg <= ref_clock_hz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      found       <= 1'b0;
      finishing   <= 1'b0;
      held_prediv <= '0;
      held_fbdiv  <= '0;
      held_rate   <= '0;
    end else begin
      if (result_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            fout      <= (target_rate > TGT_W'(MAX_TARGET_HZ)) ? MAX_TARGET_HZ
                                                               : target_rate[RATE_W-1:0];
            fref      <= fref_in;
            p         <= pmin;
            found_any <= 1'b0;
            finishing <= (fref_in == '0);
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          if (search_end) begin
            if (result_load) begin
              if (found_any) begin
                held_prediv <= best_p;
                held_fbdiv  <= best_fb;
                held_rate   <= best_rate;
              end
              found     <= found_any;
              state     <= S_IDLE;
            end
          end else begin
            num   <= NUM_W'(fout) * NUM_W'(p[PD_W-1:0]);
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          // quotient above the fbdiv maximum is rejected before dividing
          if ({2'b0, num} >= {fref, {FB_W{1'b0}}}) begin
            p     <= p + PC_W'(1);
            state <= S_MUL;
          end else begin
            rem1  <= FREF_W'(num[NUM_W-1:FB_W]);
            nbits <= num[FB_W-1:0];
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem1  <= div_ge ? FREF_W'(div_trial - {1'b0, fref}) : div_trial[FREF_W-1:0];
          nbits <= {nbits[FB_W-2:0], 1'b0};
          fb    <= {fb[FB_W-2:0], div_ge};
          cnt   <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(FB_W - 1)) state <= S_CHECK;
        end
        S_CHECK: begin
          if (fb == FB_SKIP || fb < FB_MIN) begin
            p     <= p + PC_W'(1);
            state <= S_MUL;
          end else begin
            prod  <= PROD_W'(fb) * PROD_W'(fref);
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_RATE;
        end
        S_RATE: begin
          if (div_done) begin
            rate  <= div_quot;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (!found_any || delta < best_delta) begin
            best_p     <= p[PD_W-1:0];
            best_fb    <= fb;
            best_rate  <= rate;
            best_delta <= delta;
            found_any  <= 1'b1;
          end
          // exact match stops the search
          if (delta == '0) finishing <= 1'b1;
          p     <= p + PC_W'(1);
          state <= S_MUL;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pds_rate_div u_rate_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (prod),
    .divisor  (p[PD_W-1:0]),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign pre_divider      = held_prediv;
  assign feedback_divider = held_fbdiv;
  assign achieved_rate    = held_rate;

  a_result_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_MUL))
    else $error("result raised outside the end of a search");

  a_fb_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem1 < fref)
    else $error("feedback divider remainder not below fref");

  a_found_is_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |->
      pre_divider != '0 && feedback_divider >= FB_MIN && feedback_divider != FB_SKIP)
    else $error("reported setting is not a legal divider pair");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_RATE)
    else $error("rate division finished outside its wait state");

  a_rate_not_above_target: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |-> rate <= fout)
    else $error("achieved rate above target");

endmodule
